>>> rtl/lstg_pkg.sv
// Shared types, mode constants and helpers of the leg step trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

package lstg_pkg;

    // Points in one half of a full move.
    localparam int HALF_POINTS = 16;
    localparam int MAX_OUT     = 32;

    // Field widths
    localparam int COORD_W = 16;
    localparam int LIFT_W  = 14;
    localparam int IDX_W   = 5;
    localparam int CFG_W   = 2;

    // Shared multiply-accumulate widths
    localparam int OPA_W = 30;
    localparam int ACC_W = 61;

    // Bias and reciprocal scale of the constant divide
    localparam int BIAS_SHIFT = 27;
    localparam int RECIP_SHIFT = 29;
    localparam int Q0_W = 28;

    // Segment geometry of both modes
    localparam int SEG_FULL   = HALF_POINTS;
    localparam int SEG_FIRST  = HALF_POINTS / 2;
    localparam int N_FULL     = (SEG_FULL > 1) ? SEG_FULL - 1 : 1;
    localparam int N_FIRST    = (SEG_FIRST > 1) ? SEG_FIRST - 1 : 1;
    localparam int C_FULL     = 2 * N_FULL * N_FULL;
    localparam int C_FIRST    = 2 * N_FIRST * N_FIRST;
    localparam int K_FULL     = ((2 ** BIAS_SHIFT) + C_FULL - 1) / C_FULL;
    localparam int K_FIRST    = ((2 ** BIAS_SHIFT) + C_FIRST - 1) / C_FIRST;
    localparam int BIAS_FULL  = N_FULL * N_FULL + K_FULL * C_FULL;
    localparam int BIAS_FIRST = N_FIRST * N_FIRST + K_FIRST * C_FIRST;
    localparam int M_FULL     = (2 ** RECIP_SHIFT) / C_FULL;
    localparam int M_FIRST    = (2 ** RECIP_SHIFT) / C_FIRST;
    localparam int TOTAL_FULL  = (2 * SEG_FULL > MAX_OUT) ? MAX_OUT : 2 * SEG_FULL;
    localparam int TOTAL_FIRST = (2 * SEG_FIRST > MAX_OUT) ? MAX_OUT : 2 * SEG_FIRST;

    localparam int PN_W = 12;
    localparam int AB_W = 9;
    localparam int K_W  = 27;

    // Request modes
    localparam logic CMD_FULL  = 1'b0;
    localparam logic CMD_FIRST = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] REG_HOME_X = 2'd0;
    localparam logic [CFG_W-1:0] REG_HOME_Y = 2'd1;
    localparam logic [CFG_W-1:0] REG_HOME_Z = 2'd2;

    // Coordinate axes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HAB,
        ST_NUM,
        ST_REC,
        ST_COR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [5:0]             seg;
        logic [5:0]             total;
        logic [4:0]             n;
        logic [11:0]            c;
        logic [OPA_W-1:0]       m;
        logic [OPA_W-1:0]       bias;
        logic [K_W-1:0]         k;
        logic signed [PN_W-1:0] pn_arch0;
        logic signed [PN_W-1:0] pn_line0;
        logic signed [PN_W-1:0] dp_arch;
        logic signed [PN_W-1:0] dp_line;
    } t_mode;

    typedef struct packed {
        logic signed [OPA_W-1:0] a;
        logic signed [OPA_W-1:0] b;
        logic signed [OPA_W-1:0] c;
    } t_mac_op;

    function automatic t_mode mode_of(input logic cmd);
        t_mode md;
        if (cmd == CMD_FIRST) begin
            md.seg      = 6'(SEG_FIRST);
            md.total    = 6'(TOTAL_FIRST);
            md.n        = 5'(N_FIRST);
            md.c        = 12'(C_FIRST);
            md.m        = OPA_W'(M_FIRST);
            md.bias     = OPA_W'(BIAS_FIRST);
            md.k        = K_W'(K_FIRST);
            md.pn_arch0 = '0;
            md.pn_line0 = '0;
            md.dp_arch  = PN_W'(N_FIRST);
            md.dp_line  = PN_W'(-N_FIRST);
        end else begin
            md.seg      = 6'(SEG_FULL);
            md.total    = 6'(TOTAL_FULL);
            md.n        = 5'(N_FULL);
            md.c        = 12'(C_FULL);
            md.m        = OPA_W'(M_FULL);
            md.bias     = OPA_W'(BIAS_FULL);
            md.k        = K_W'(K_FULL);
            md.pn_arch0 = PN_W'(-(N_FULL * N_FULL));
            md.pn_line0 = PN_W'(N_FULL * N_FULL);
            md.dp_arch  = PN_W'(2 * N_FULL);
            md.dp_line  = PN_W'(-2 * N_FULL);
        end
        return md;
    endfunction

    // Clamp to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [OPA_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > OPA_W'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -OPA_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lstg_req_if.sv
// Request channel of the leg step trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

interface lstg_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [13:0] lift_height;

    modport source (output valid, cmd, dir_x, dir_y, dir_z, lift_height, input ready);
    modport sink   (input valid, cmd, dir_x, dir_y, dir_z, lift_height, output ready);
endinterface

`default_nettype wire

>>> rtl/lstg_pt_if.sv
// Foot point channel of the leg step trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

interface lstg_pt_if;
    logic        valid;
    logic        ready;
    logic [4:0]  point_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic        last;

    modport source (output valid, point_index, pos_x, pos_y, pos_z, last, input ready);
    modport sink   (input valid, point_index, pos_x, pos_y, pos_z, last, output ready);
endinterface

`default_nettype wire

>>> rtl/lstg_mac.sv
// Shared registered multiply-accumulate unit of the trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

module lstg_mac
    import lstg_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire t_mac_op                 i_op,
    output logic signed [ACC_W-1:0]      o_acc
);

    logic signed [2*OPA_W-1:0] w_mul;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   r_acc;

    always_comb begin
        w_mul = i_op.a * i_op.b;
        n_acc = ACC_W'(w_mul) + ACC_W'(i_op.c);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> rtl/leg_step_trajectory_generator_unit.sv
// Top level of the leg step trajectory generator: sequencer, point state and output register.
`timescale 1ns / 1ps
`default_nettype none

// One request (mode, step direction D, lift height h) produces a path of foot
// points relative to the home position set through the configuration port.
// A full move gives HALF_POINTS points on a quadratic Bezier arch from
// home - D/2 to home + D/2 with the control point raised by 2h, followed by
// HALF_POINTS points on the straight return line; a first move gives half as
// many points on each part, starting at home. At most 32 points are sent and
// the final one carries last. Each coordinate is home + round(offset) with the
// offset rounded half up and the result saturated to 16 bits.
// All arithmetic runs through one registered multiply-accumulate unit. Per
// point the sequencer computes the lift term, then for each axis the
// numerator, the reciprocal multiply and the remainder check, and then hands
// the point to the output register, waiting while the sink holds off a
// finished point. The block takes a new request only when the previous path
// has been fully computed; the last point may still wait in the output
// register meanwhile.
// Home coordinates should only be written while no request is in progress.

module leg_step_trajectory_generator_unit
    import lstg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_idx,
    input  wire logic [15:0]      i_cfg_wdata,
    lstg_req_if.sink              i_req,
    lstg_pt_if.source             o_pt
);

    // Sequencer
    t_state r_state, n_state;
    logic [1:0]       r_c;           // axis in progress
    logic [IDX_W-1:0] r_k;           // point position in the path
    logic [4:0]       r_i;           // index inside the current segment
    logic             r_line;        // return line segment
    logic             r_cmd;

    // Request payload
    logic signed [COORD_W-1:0] r_dir [3];
    logic [LIFT_W-1:0]         r_h;

    // Running point terms: p*N and a*b of the Bezier weights
    logic signed [PN_W-1:0] r_pn;
    logic [AB_W-1:0]        r_ab;

    // Home registers and home minus the divide bias
    logic signed [COORD_W-1:0] r_home [3];
    logic signed [K_W:0]       r_hk [3];

    // Datapath captures
    logic [OPA_W-1:0]          r_zb;  // bias plus lift term for z
    logic [OPA_W-1:0]          r_x;   // biased numerator
    logic [Q0_W-1:0]           r_q0;  // quotient estimate
    logic signed [COORD_W-1:0] r_pos [2];

    // Output register
    logic                      r_ovalid;
    logic [IDX_W-1:0]          r_oidx;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic                      r_olast;

    t_mode                     mode;
    t_mode                     req_mode;
    t_mac_op                   mac_op;
    logic                      mac_en;
    logic signed [ACC_W-1:0]   acc;

    logic                      req_take;
    logic                      out_take;
    logic                      emit_load;
    logic                      is_last;
    logic                      arch_end;
    logic [1:0]                fix_axis;
    logic                      fix_corr;
    logic signed [OPA_W-1:0]   fix_sum;
    logic signed [COORD_W-1:0] fix_val;
    logic signed [9:0]         ab_step;

    assign mode     = mode_of(r_cmd);
    assign req_mode = mode_of(i_req.cmd);

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign out_take    = r_ovalid && o_pt.ready;
    assign emit_load   = (r_state == ST_EMIT) && (!r_ovalid || o_pt.ready);
    assign is_last     = ({1'b0, r_k} == (mode.total - 6'd1));
    assign arch_end    = !r_line && (r_i == mode.n);

    // Finish the divide of the axis whose remainder sits in the accumulator.
    assign fix_axis = (r_state == ST_EMIT) ? AX_Z : (r_c - 2'd1);
    assign fix_corr = (acc[OPA_W:0] >= (OPA_W + 1)'(mode.c));
    always_comb begin
        fix_sum = $signed({2'b00, r_q0}) + OPA_W'(r_hk[fix_axis]) + OPA_W'(fix_corr);
        fix_val = sat_coord(fix_sum);
    end

    // Bezier cross term step: (n-i-1)(i+1) - (n-i)i = n - 2i - 1
    assign ab_step = $signed({5'b0, mode.n}) - $signed({4'b0, r_i, 1'b0}) - 10'sd1;

    // Operand select of the shared unit
    always_comb begin
        mac_op = '0;
        mac_en = 1'b0;
        unique case (r_state)
            ST_HAB: begin
                mac_en   = 1'b1;
                mac_op.a = OPA_W'(r_h);
                mac_op.b = r_line ? '0 : OPA_W'({r_ab, 3'b000});
                mac_op.c = mode.bias;
            end
            ST_NUM: begin
                mac_en   = 1'b1;
                mac_op.a = OPA_W'(r_dir[r_c]);
                mac_op.b = OPA_W'(r_pn);
                mac_op.c = (r_c == AX_Z) ? r_zb : mode.bias;
            end
            ST_REC: begin
                mac_en   = 1'b1;
                mac_op.a = acc[OPA_W-1:0];
                mac_op.b = mode.m;
                mac_op.c = '0;
            end
            ST_COR: begin
                mac_en   = 1'b1;
                mac_op.a = OPA_W'(acc[RECIP_SHIFT+Q0_W-1:RECIP_SHIFT]);
                mac_op.b = -$signed(OPA_W'(mode.c));
                mac_op.c = r_x;
            end
            ST_IDLE, ST_EMIT: begin
                mac_en = 1'b0;
            end
            default: begin
                mac_en = 1'b0;
            end
        endcase
    end

    lstg_mac u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_op  (mac_op),
        .o_acc (acc)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_take) begin
                    n_state = ST_HAB;
                end
            end
            ST_HAB: n_state = ST_NUM;
            ST_NUM: n_state = ST_REC;
            ST_REC: n_state = ST_COR;
            ST_COR: begin
                n_state = (r_c == AX_Z) ? ST_EMIT : ST_NUM;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_state = is_last ? ST_IDLE : ST_HAB;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_home[0] <= '0;
            r_home[1] <= '0;
            r_home[2] <= '0;
        end else begin
            r_state <= n_state;
            if (emit_load) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HOME_X: r_home[0] <= i_cfg_wdata;
                    REG_HOME_Y: r_home[1] <= i_cfg_wdata;
                    REG_HOME_Z: r_home[2] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Point sequencing and datapath captures
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            // Latch the request and start the arch segment.
            r_cmd    <= i_req.cmd;
            r_dir[0] <= i_req.dir_x;
            r_dir[1] <= i_req.dir_y;
            r_dir[2] <= i_req.dir_z;
            r_h      <= i_req.lift_height;
            r_k      <= '0;
            r_i      <= '0;
            r_line   <= 1'b0;
            r_c      <= AX_X;
            r_pn     <= req_mode.pn_arch0;
            r_ab     <= '0;
            for (int ax = 0; ax < 3; ax++) begin
                r_hk[ax] <= (K_W + 1)'(r_home[ax]) - $signed({1'b0, req_mode.k});
            end
        end

        unique case (r_state)
            ST_NUM: begin
                if (r_c == AX_X) begin
                    r_zb <= acc[OPA_W-1:0];
                end else begin
                    r_pos[fix_axis[0]] <= fix_val;
                end
            end
            ST_REC: begin
                r_x <= acc[OPA_W-1:0];
            end
            ST_COR: begin
                r_q0 <= acc[RECIP_SHIFT+Q0_W-1:RECIP_SHIFT];
                if (r_c != AX_Z) begin
                    r_c <= r_c + 2'd1;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    r_oidx  <= r_k;
                    r_ox    <= r_pos[0];
                    r_oy    <= r_pos[1];
                    r_oz    <= fix_val;
                    r_olast <= is_last;
                    // Advance to the next point.
                    r_c <= AX_X;
                    r_k <= r_k + IDX_W'(1);
                    if (arch_end) begin
                        r_line <= 1'b1;
                        r_i    <= '0;
                        r_pn   <= mode.pn_line0;
                        r_ab   <= '0;
                    end else begin
                        r_i  <= r_i + 5'd1;
                        r_pn <= r_pn + (r_line ? mode.dp_line : mode.dp_arch);
                        r_ab <= AB_W'(10'(r_ab) + ab_step);
                    end
                end
            end
            ST_IDLE, ST_HAB: ;
            default: ;
        endcase
    end

    assign o_pt.valid       = r_ovalid;
    assign o_pt.point_index = r_oidx;
    assign o_pt.pos_x       = r_ox;
    assign o_pt.pos_y       = r_oy;
    assign o_pt.pos_z       = r_oz;
    assign o_pt.last        = r_olast;

endmodule

`default_nettype wire
